// ----- design/iqlir_pkg.sv -----
// ----------------------------------------------------------------------------
// iqlir_pkg: shared types and constants of the IQ linear interpolation resampler
// Holds the field widths, the default block length and the queue word format.
// ----------------------------------------------------------------------------
package iqlir_pkg;

  // Field widths.
  localparam int unsigned SampleW  = 32;
  localparam int unsigned RawW     = 2 * SampleW;
  localparam int unsigned FracW    = 11;
  localparam int unsigned IdxW     = 13;
  localparam int unsigned PosW     = 23;
  localparam int unsigned OutW     = 43;
  localparam int unsigned WeightW  = FracW + 1;
  localparam int unsigned ProdW    = SampleW + WeightW + 1;

  // Block length default and queue depth.
  localparam int unsigned DefInBlock = 3072;
  localparam int unsigned DefQDepth  = 2;

  // One interpolation job: both neighbors and the fraction.
  typedef struct packed {
    logic signed [SampleW-1:0] prev_i;
    logic signed [SampleW-1:0] prev_q;
    logic signed [SampleW-1:0] cur_i;
    logic signed [SampleW-1:0] cur_q;
    logic        [FracW-1:0]   frac;
  } job_t;

  // Write side of the job queue.
  typedef struct packed {
    logic valid;
    job_t job;
  } q_push_t;

endpackage

// ----- design/iqlir_front.sv -----
// ----------------------------------------------------------------------------
// iqlir_front: sample intake and output scheduling
// Takes one sample word per cycle while the queue has room, applies the IQ
// swap, tracks the block position and pushes a job when an output is due.
// ----------------------------------------------------------------------------
module iqlir_front
  import iqlir_pkg::*;
#(
  parameter int unsigned InBlock = DefInBlock
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [RawW-1:0]   raw_sample_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic              cfg_iq_swap_i,
  input  logic              q_full_i,
  output q_push_t           q_push_o
);

  localparam logic [IdxW-1:0] InBlockIdx = IdxW'(InBlock);
  localparam logic [PosW-1:0] InBlockPos = PosW'(InBlock);

  logic                      swap_q;
  logic                      first_q, first_d;
  logic [IdxW-1:0]           in_idx_q, in_idx_d;
  logic [FracW-1:0]          out_idx_q, out_idx_d;
  logic [PosW-1:0]           pos_q, pos_d;
  logic signed [SampleW-1:0] prev_i_q, prev_q_q;
  logic signed [SampleW-1:0] cur_i, cur_q;
  logic [IdxW-1:0]           base;
  logic                      block_end;
  logic                      emit;
  logic                      accept;

  // The configuration register is always writable.
  assign cfg_ready_o = 1'b1;

  // Stall only when the job queue cannot take another word.
  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Split the word and apply the swap.
  assign cur_i = swap_q ? $signed(raw_sample_i[RawW-1:SampleW])
                        : $signed(raw_sample_i[SampleW-1:0]);
  assign cur_q = swap_q ? $signed(raw_sample_i[SampleW-1:0])
                        : $signed(raw_sample_i[RawW-1:SampleW]);

  // An output is due when its right-hand sample has arrived, unless the
  // block is already complete at its last sample.
  assign base      = IdxW'(pos_q[PosW-1:FracW]);
  assign block_end = (in_idx_q >= InBlockIdx);
  assign emit      = !first_q && (base < in_idx_q) &&
                     !(block_end && (out_idx_q == '0));

  // Block position bookkeeping.
  always_comb begin
    first_d   = first_q;
    in_idx_d  = in_idx_q;
    out_idx_d = out_idx_q;
    pos_d     = pos_q;
    if (accept) begin
      if (first_q) begin
        first_d   = 1'b0;
        in_idx_d  = IdxW'(1);
        out_idx_d = '0;
        pos_d     = '0;
      end else begin
        if (emit) begin
          out_idx_d = out_idx_q + FracW'(1);
          pos_d     = pos_q + InBlockPos;
        end
        if (block_end) begin
          in_idx_d  = IdxW'(1);
          out_idx_d = '0;
          pos_d     = '0;
        end else begin
          in_idx_d  = in_idx_q + IdxW'(1);
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      swap_q    <= 1'b0;
      first_q   <= 1'b1;
      in_idx_q  <= '0;
      out_idx_q <= '0;
      pos_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        swap_q <= cfg_iq_swap_i;
      end
      first_q   <= first_d;
      in_idx_q  <= in_idx_d;
      out_idx_q <= out_idx_d;
      pos_q     <= pos_d;
    end
  end

  // Previous sample; the first sample always loads it before use.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      prev_i_q <= cur_i;
      prev_q_q <= cur_q;
    end
  end

  // Job word toward the queue.
  always_comb begin
    q_push_o.valid      = accept && emit;
    q_push_o.job.prev_i = prev_i_q;
    q_push_o.job.prev_q = prev_q_q;
    q_push_o.job.cur_i  = cur_i;
    q_push_o.job.cur_q  = cur_q;
    q_push_o.job.frac   = pos_q[FracW-1:0];
  end

endmodule

// ----- design/iqlir_queue.sv -----
// ----------------------------------------------------------------------------
// iqlir_queue: short job queue between intake and arithmetic
// A small register FIFO that lets the front and the back stall separately.
// ----------------------------------------------------------------------------
module iqlir_queue
  import iqlir_pkg::*;
#(
  parameter int unsigned Depth = DefQDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  q_push_t                      push_i,
  output logic                         full_o,
  output logic                         pop_valid_o,
  input  logic                         pop_ready_i,
  output job_t                         pop_job_o,
  output logic [$clog2(Depth+1)-1:0]   level_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  job_t            slots_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o      = (count_q == CntW'(Depth));
  assign pop_valid_o = (count_q != '0);
  assign pop_job_o   = slots_q[rd_ptr_q];
  assign level_o     = count_q;
  assign do_push     = push_i.valid && !full_o;
  assign do_pop      = pop_valid_o && pop_ready_i;

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // Slot storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_i.job;
    end
  end

endmodule

// ----- design/iqlir_back.sv -----
// ----------------------------------------------------------------------------
// iqlir_back: interpolation arithmetic
// Stage one forms the four weighted products, stage two adds them into the
// output register that drives the result channel.
// ----------------------------------------------------------------------------
module iqlir_back
  import iqlir_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  output logic                   job_ready_o,
  input  job_t                   job_i,
  output logic                   mul_busy_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [OutW-1:0] out_i_o,
  output logic signed [OutW-1:0] out_q_o
);

  localparam logic [WeightW-1:0] FracOne = WeightW'(1 << FracW);

  logic                    s1_valid_q;
  logic                    out_valid_q;
  logic                    s1_ready, out_ready_int;
  logic [WeightW-1:0]      w_prev, w_cur;
  logic signed [ProdW-1:0] pa_i, pb_i, pa_q, pb_q;
  logic signed [ProdW-1:0] pa_i_q, pb_i_q, pa_q_q, pb_q_q;
  logic signed [OutW-1:0]  out_i_q, out_q_q;

  // Each stage moves when the next one can take its word.
  assign out_ready_int = !out_valid_q || out_ready_i;
  assign s1_ready      = !s1_valid_q || out_ready_int;
  assign job_ready_o   = s1_ready;
  assign mul_busy_o    = s1_valid_q;

  // Weights 2048-f and f, then the four products.
  assign w_prev = FracOne - {1'b0, job_i.frac};
  assign w_cur  = {1'b0, job_i.frac};
  assign pa_i   = job_i.prev_i * $signed({1'b0, w_prev});
  assign pb_i   = job_i.cur_i  * $signed({1'b0, w_cur});
  assign pa_q   = job_i.prev_q * $signed({1'b0, w_prev});
  assign pb_q   = job_i.cur_q  * $signed({1'b0, w_cur});

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= job_valid_i;
      end
      if (out_ready_int) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Stage data. The sum always fits the output width.
  always_ff @(posedge clk_i) begin
    if (s1_ready && job_valid_i) begin
      pa_i_q <= pa_i;
      pb_i_q <= pb_i;
      pa_q_q <= pa_q;
      pb_q_q <= pb_q;
    end
    if (out_ready_int && s1_valid_q) begin
      out_i_q <= OutW'(pa_i_q) + OutW'(pb_i_q);
      out_q_q <= OutW'(pa_q_q) + OutW'(pb_q_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_i_o     = out_i_q;
  assign out_q_o     = out_q_q;

endmodule

// ----- design/iq_linear_interp_resampler.sv -----
// ----------------------------------------------------------------------------
// iq_linear_interp_resampler: IQ linear interpolation resampler
// Resamples blocks of IN_BLOCK complex samples to 2048 outputs each by
// linear interpolation, with an optional exchange of I and Q.
// ----------------------------------------------------------------------------
//   channel | direction | handshake                | word
//   --------+-----------+--------------------------+----------------------------
//   input   | in        | in_valid_i / in_ready_o  | raw_sample_i (I low, Q high)
//   result  | out       | out_valid_o / out_ready_i| out_i_o, out_q_o
//   config  | in        | cfg_valid_i / cfg_ready_o| cfg_iq_swap_i
//
// One sample is accepted every cycle while the job queue has room. The queue
// slot is written at the accepting edge; the job then passes the product
// stage register and the output register before its result is offered.
// Reset puts the block at the first sample of a new stream with no swap.
// A stalled result channel fills the two-entry queue, and only then does
// in_ready_o drop.
// ----------------------------------------------------------------------------
module iq_linear_interp_resampler
  import iqlir_pkg::*;
#(
  parameter int unsigned IN_BLOCK = DefInBlock,
  parameter int unsigned QDepth   = DefQDepth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [RawW-1:0]        raw_sample_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic signed [OutW-1:0] out_i_o,
  output logic signed [OutW-1:0] out_q_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic                   cfg_iq_swap_i
);

  q_push_t                      q_push;
  logic                         q_full;
  logic                         q_pop_valid, q_pop_ready;
  job_t                         q_pop_job;
  logic [$clog2(QDepth+1)-1:0]  q_level;
  logic                         mul_busy;

  // Intake and scheduling.
  iqlir_front #(
    .InBlock (IN_BLOCK)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .raw_sample_i  (raw_sample_i),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_iq_swap_i (cfg_iq_swap_i),
    .q_full_i      (q_full),
    .q_push_o      (q_push)
  );

  // Job queue.
  iqlir_queue #(
    .Depth (QDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .full_o      (q_full),
    .pop_valid_o (q_pop_valid),
    .pop_ready_i (q_pop_ready),
    .pop_job_o   (q_pop_job),
    .level_o     (q_level)
  );

  // Arithmetic and result register.
  iqlir_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (q_pop_valid),
    .job_ready_o (q_pop_ready),
    .job_i       (q_pop_job),
    .mul_busy_o  (mul_busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_i_o     (out_i_o),
    .out_q_o     (out_q_o)
  );

`ifndef SYNTHESIS
  // The front never pushes a job into a full queue.
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_push.valid |-> !q_full)
    else $error("job pushed into a full queue");

  // A new result always comes out of the product stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(mul_busy))
    else $error("result appeared without a product stage word");

  // The queue level never passes its depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_level <= ($clog2(QDepth+1))'(QDepth))
    else $error("queue level beyond its depth");
`endif

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for the IQ linear interpolation resampler
// Drives raw IQ words through the valid/ready input channel, predicts each
// interpolated output word with a cycle-free model of the resampler, and
// checks every output word field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module tb;
  import iqlir_pkg::*;

  localparam int unsigned InBlock      = DefInBlock;
  localparam int unsigned RandPhases   = 4;
  localparam int unsigned PhaseWords   = 308;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned CycleLimit   = 1_000_000;
  localparam int unsigned MaxShown     = 10;

  localparam logic [SampleW-1:0] SMax = 32'h7FFF_FFFF;
  localparam logic [SampleW-1:0] SMin = 32'h8000_0000;

  // Output extremes: the largest and smallest sample times 2048.
  localparam logic signed [OutW-1:0] OutMax = 43'sh3FF_FFFF_F800;
  localparam logic signed [OutW-1:0] OutMin = 43'sh400_0000_0000;

  typedef enum logic {
    CHECK_PREDICTED,
    CHECK_TYPED
  } row_check_e;

  typedef struct packed {
    logic signed [OutW-1:0] i;
    logic signed [OutW-1:0] q;
  } iq_pair_t;

  typedef struct {
    row_check_e             chk;
    logic [RawW-1:0]        raw;
    logic signed [OutW-1:0] want_i;
    logic signed [OutW-1:0] want_q;
  } stim_row_t;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [RawW-1:0]        raw_sample_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic signed [OutW-1:0] out_i_o;
  logic signed [OutW-1:0] out_q_o;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic                   cfg_iq_swap_i;

  // Resampler state as the bench sees it.
  logic [SampleW-1:0] held_i;
  logic [SampleW-1:0] held_q;
  logic [IdxW-1:0]    next_idx;
  logic [FracW-1:0]   out_num;
  logic [PosW-1:0]    out_pos;
  bit                 awaiting_first;
  bit                 swap_iq;

  iq_pair_t    pending_outputs[$];
  int unsigned fail_count;
  int unsigned cycle_count;
  bit          no_idle;

  // Directed words, raw packed as {Q, I}. Typed rows hold outputs that are
  // plain to see: the first output is sample zero times 2048, and with
  // equal neighbors the fraction drops out.
  stim_row_t directed_rows [18] = '{
    '{CHECK_PREDICTED, {SMin, SMax}, '0, '0},
    '{CHECK_TYPED,     {SMax, SMin}, OutMax, OutMin},
    '{CHECK_TYPED,     {SMax, SMin}, OutMin, OutMax},
    '{CHECK_PREDICTED, {32'h0, 32'h0}, '0, '0},
    '{CHECK_PREDICTED, {32'hFFFF_FFFF, 32'hFFFF_FFFF}, '0, '0},
    '{CHECK_PREDICTED, {32'hFFFF_FFFF, 32'h0000_0001}, '0, '0},
    '{CHECK_PREDICTED, {32'hAAAA_AAAA, 32'h5555_5555}, '0, '0},
    '{CHECK_PREDICTED, {32'h5555_5555, 32'hAAAA_AAAA}, '0, '0},
    '{CHECK_PREDICTED, {SMax, SMax}, '0, '0},
    '{CHECK_PREDICTED, {SMin, SMin}, '0, '0},
    '{CHECK_PREDICTED, {SMax, 32'h0}, '0, '0},
    '{CHECK_PREDICTED, {32'h0, SMin}, '0, '0},
    '{CHECK_PREDICTED, {32'hFEDC_BA98, 32'h1234_5678}, '0, '0},
    '{CHECK_PREDICTED, {32'hFFFF_0000, 32'h0001_0000}, '0, '0},
    '{CHECK_PREDICTED, {SMin, SMax}, '0, '0},
    '{CHECK_PREDICTED, {32'h0000_0001, 32'hFFFF_FFFF}, '0, '0},
    '{CHECK_PREDICTED, {32'h0, 32'h0}, '0, '0},
    '{CHECK_PREDICTED, {32'hFFFF_0000, 32'h0000_FFFF}, '0, '0}
  };

  iq_linear_interp_resampler #(
    .IN_BLOCK(InBlock)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .raw_sample_i (raw_sample_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_i_o      (out_i_o),
    .out_q_o      (out_q_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_iq_swap_i(cfg_iq_swap_i)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // Blend two samples: a*(2048-f) + b*f, kept to the output width.
  function automatic logic signed [OutW-1:0] blend(input logic [SampleW-1:0] a,
                                                   input logic [SampleW-1:0] b,
                                                   input logic [FracW-1:0] f);
    longint w;
    longint acc;
    w   = 2048 - longint'(f);
    acc = longint'($signed(a)) * w + longint'($signed(b)) * longint'(f);
    return acc[OutW-1:0];
  endfunction

  // Advance the resampler by one input word; got says whether it emits.
  task automatic resample_step(input logic [RawW-1:0] raw, output bit got,
                               output iq_pair_t res);
    logic [SampleW-1:0]    ci;
    logic [SampleW-1:0]    cq;
    logic [IdxW-1:0]       k;
    logic [PosW-FracW-1:0] base;
    logic [FracW-1:0]      f;
    ci   = swap_iq ? raw[RawW-1:SampleW] : raw[SampleW-1:0];
    cq   = swap_iq ? raw[SampleW-1:0] : raw[RawW-1:SampleW];
    got  = 1'b0;
    res  = '0;
    k    = next_idx;
    base = out_pos[PosW-1:FracW];
    f    = out_pos[FracW-1:0];
    if (awaiting_first) begin
      // The very first sample only becomes the left neighbor.
      awaiting_first = 1'b0;
      next_idx       = IdxW'(1);
      out_num        = '0;
      out_pos        = '0;
    end else begin
      // A finished block emits nothing more at its closing sample.
      if (base < k && !(k >= InBlock && out_num == 0)) begin
        got     = 1'b1;
        res.i   = blend(held_i, ci, f);
        res.q   = blend(held_q, cq, f);
        out_num = out_num + 1'b1;
        out_pos = out_pos + PosW'(InBlock);
      end
      // The closing sample opens the next block as its sample zero.
      if (k >= InBlock) begin
        next_idx = IdxW'(1);
        out_num  = '0;
        out_pos  = '0;
      end else begin
        next_idx = k + 1'b1;
      end
    end
    held_i = ci;
    held_q = cq;
  endtask

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sample words lean toward the extremes of the signed range.
  function automatic logic [SampleW-1:0] rand_word();
    case ($urandom_range(0, 7))
      0: return SMin;
      1: return SMax;
      2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default: return $urandom;
    endcase
  endfunction

  task automatic log_mismatch(input string what, input logic signed [OutW-1:0] want,
                              input logic signed [OutW-1:0] got);
    fail_count++;
    if (fail_count <= MaxShown)
      $display("tb: mismatch on %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic check_result(input logic signed [OutW-1:0] got_i,
                              input logic signed [OutW-1:0] got_q);
    iq_pair_t want;
    if (pending_outputs.size() == 0) begin
      log_mismatch("unexpected word (i)", '0, got_i);
    end else begin
      want = pending_outputs.pop_front();
      if (got_i !== want.i) log_mismatch("out_i", want.i, got_i);
      if (got_q !== want.q) log_mismatch("out_q", want.q, got_q);
    end
  endtask

  // Present one word, wait for its acceptance, then idle for gap cycles.
  task automatic send_sample(input stim_row_t row, input int unsigned gap);
    bit       got;
    iq_pair_t res;
    in_valid_i   <= 1'b1;
    raw_sample_i <= row.raw;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    resample_step(row.raw, got, res);
    if (got) begin
      if (row.chk == CHECK_TYPED) pending_outputs.push_back('{row.want_i, row.want_q});
      else pending_outputs.push_back(res);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold the input until every expected word is out and the pipe is empty.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_swap(input bit value);
    cfg_valid_i   <= 1'b1;
    cfg_iq_swap_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    swap_iq = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Run timeout.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // Output side: check accepted words and stall at random.
  initial begin : result_side
    int unsigned hold;
    hold = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) check_result(out_i_o, out_q_o);
      if (hold != 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
        hold = pick_gap();
      end
    end
  end

  // Input side: reset, directed words, then random phases with swap changes.
  initial begin : stimulus
    stim_row_t row;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    raw_sample_i  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_iq_swap_i <= 1'b0;
    no_idle        = 1'b0;
    swap_iq        = 1'b0;
    held_i         = '0;
    held_q         = '0;
    next_idx       = '0;
    out_num        = '0;
    out_pos        = '0;
    awaiting_first = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_swap(1'b0);

    foreach (directed_rows[r]) send_sample(directed_rows[r], pick_gap());

    // The random phases alternate the swap, and one of them runs with no gaps.
    for (int unsigned phase = 0; phase < RandPhases; phase++) begin
      wait_drained();
      write_swap(phase % 2 == 0);
      no_idle = (phase == 2);
      for (int unsigned n = 0; n < PhaseWords; n++) begin
        row.chk    = CHECK_PREDICTED;
        row.raw    = {rand_word(), rand_word()};
        row.want_i = '0;
        row.want_q = '0;
        send_sample(row, pick_gap());
      end
    end

    wait_drained();
    if (fail_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/iqlir_pkg.sv
design/iqlir_front.sv
design/iqlir_queue.sv
design/iqlir_back.sv
design/iq_linear_interp_resampler.sv
tb/tb.sv
